// File: rtl/sha256s_pkg.sv
// sha-256 stream hasher: shared types, round constants and initial hash values
`default_nettype none

package sha256s_pkg;

    typedef logic [31:0] word_t;

    // eight working or chaining words, index 0 is word a
    typedef logic [7:0][31:0] hash_t;

    // sixteen schedule words, index 15 holds the word used in the current round
    typedef logic [15:0][31:0] window_t;

    // input item payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_of_message;
    } msg_t;

    // result item payload
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [5:0] LEN_AT     = 6'd56;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    // initial hash value, word 7 down to word 0
    localparam hash_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

// File: rtl/sha256s_stream_if.sv
// valid/ready stream channel carrying one item payload
`default_nettype none

interface sha256s_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/sha256s_round.sv
// one sha-256 compression round plus one message schedule step
`default_nettype none

module sha256s_round (
    input  wire sha256s_pkg::hash_t   state,
    input  wire sha256s_pkg::window_t window,
    input  wire sha256s_pkg::word_t   k,
    output sha256s_pkg::hash_t        state_next,
    output sha256s_pkg::word_t        w_new
);

    sha256s_pkg::word_t a, b, c, d, e, f, g, h, w;
    sha256s_pkg::word_t big0, big1, ch, mj, t1, t2;
    sha256s_pkg::word_t x1, x14, s0, s1;

    // working words and the schedule word for this round
    always_comb
    begin
        a = state[0];
        b = state[1];
        c = state[2];
        d = state[3];
        e = state[4];
        f = state[5];
        g = state[6];
        h = state[7];
        w = window[15];
    end

    // round function
    always_comb
    begin
        big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch   = (e & f) ^ (~e & g);
        t1   = h + big1 + ch + k + w;
        big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        mj   = (a & b) ^ (a & c) ^ (b & c);
        t2   = big0 + mj;

        state_next[0] = t1 + t2;
        state_next[1] = a;
        state_next[2] = b;
        state_next[3] = c;
        state_next[4] = d + t1;
        state_next[5] = e;
        state_next[6] = f;
        state_next[7] = g;
    end

    // schedule word sixteen rounds ahead of the current one
    always_comb
    begin
        x1    = window[14];
        x14   = window[1];
        s0    = {x1[6:0], x1[31:7]} ^ {x1[17:0], x1[31:18]} ^ {3'b000, x1[31:3]};
        s1    = {x14[16:0], x14[31:17]} ^ {x14[18:0], x14[31:19]} ^ {10'd0, x14[31:10]};
        w_new = window[15] + s0 + window[6] + s1;
    end

endmodule

`default_nettype wire

// File: rtl/sha256_stream_hasher_core.sv
// sha-256 stream hasher top level: byte intake, padding sequencer and round loop
// a byte that does not complete a block is taken without starting a compression
// a byte that completes a block holds off input for the 64 rounds and the fold
// end of message: padding bytes (up to 64 per block), one or two compressions,
// then eight digest items, one per cycle while the output side is ready
// the round unit does one round per cycle; reset loads the initial hash value
// and clears counts and flags, the block buffer is not cleared
`default_nettype none

module sha256_stream_hasher_core (
    input  wire          clk,
    input  wire          rst_n,
    sha256s_stream_if.sink   msg,
    sha256s_stream_if.source digest
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]             state_reg, state_next;
    sha256s_pkg::window_t   win_reg, win_next;
    sha256s_pkg::hash_t     h_reg, h_next;
    sha256s_pkg::hash_t     v_reg, v_next;
    logic [5:0]             fill_reg, fill_next;
    logic [63:0]            bits_reg, bits_next;
    logic [5:0]             round_reg, round_next;
    logic                   pad_reg, pad_next;
    logic                   mark_reg, mark_next;
    logic                   len_ok_reg, len_ok_next;
    logic                   final_reg, final_next;
    logic [2:0]             idx_reg, idx_next;

    sha256s_pkg::msg_t      in_item;
    sha256s_pkg::hash_t     v_round;
    sha256s_pkg::word_t     w_new;
    logic [7:0]             pad_byte;

    assign in_item = msg.payload;

    // shared round unit
    sha256s_round u_round (
        .state      (v_reg),
        .window     (win_reg),
        .k          (sha256s_pkg::ROUND_K[round_reg]),
        .state_next (v_round),
        .w_new      (w_new)
    );

    // padding byte: marker, then zeros, then the big-endian bit length
    always_comb
    begin
        if (!mark_reg)
        begin
            pad_byte = sha256s_pkg::PAD_MARK;
        end
        else if (len_ok_reg && (fill_reg >= sha256s_pkg::LEN_AT))
        begin
            pad_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = sha256s_pkg::PAD_ZERO;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        win_next    = win_reg;
        h_next      = h_reg;
        v_next      = v_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        round_next  = round_reg;
        pad_next    = pad_reg;
        mark_next   = mark_reg;
        len_ok_next = len_ok_reg;
        final_next  = final_reg;
        idx_next    = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (in_item.has_data)
                    begin
                        win_next  = sha256s_pkg::window_t'({win_reg[15][23:0], win_reg[14:0],
                                                            in_item.data_byte});
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (in_item.end_of_message)
                    begin
                        pad_next   = 1'b1;
                        mark_next  = 1'b0;
                        final_next = 1'b0;
                    end
                    if (in_item.has_data && (fill_reg == sha256s_pkg::LAST_FILL))
                    begin
                        v_next     = h_reg;
                        state_next = ST_ROUND;
                    end
                    else if (in_item.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                win_next  = sha256s_pkg::window_t'({win_reg[15][23:0], win_reg[14:0], pad_byte});
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next   = 1'b1;
                    len_ok_next = (fill_reg < sha256s_pkg::LEN_AT);
                end
                if (fill_reg == sha256s_pkg::LAST_FILL)
                begin
                    v_next     = h_reg;
                    final_next = mark_reg && len_ok_reg;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                v_next     = v_round;
                win_next   = {win_reg[14:0], w_new};
                round_next = round_reg + 6'd1;
                if (round_reg == sha256s_pkg::LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    h_next[j] = h_reg[j] + v_reg[j];
                end
                if (final_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_EMIT;
                end
                else if (pad_reg)
                begin
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (digest.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256s_pkg::LAST_WORD)
                    begin
                        h_next     = sha256s_pkg::INIT_H;
                        fill_next  = 6'd0;
                        bits_next  = 64'd0;
                        pad_next   = 1'b0;
                        mark_next  = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            h_reg      <= sha256s_pkg::INIT_H;
            fill_reg   <= 6'd0;
            bits_reg   <= 64'd0;
            round_reg  <= 6'd0;
            pad_reg    <= 1'b0;
            mark_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
            final_reg  <= 1'b0;
            idx_reg    <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            h_reg      <= h_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            round_reg  <= round_next;
            pad_reg    <= pad_next;
            mark_reg   <= mark_next;
            len_ok_reg <= len_ok_next;
            final_reg  <= final_next;
            idx_reg    <= idx_next;
        end
    end

    // block buffer, schedule window and working words
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        v_reg   <= v_next;
    end

    // handshakes and result item
    assign msg.ready                  = (state_reg == ST_IDLE);
    assign digest.valid               = (state_reg == ST_EMIT);
    assign digest.payload.digest_word = h_reg[idx_reg];
    assign digest.payload.word_index  = idx_reg;
    assign digest.payload.last_word   = (idx_reg == sha256s_pkg::LAST_WORD);

    // round counter only runs during compression
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND) |-> (round_reg == 6'd0))
        else $error("round counter not idle outside compression");

    // a compression starts only on a full block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd0)
            |-> ($past(fill_reg) == sha256s_pkg::LAST_FILL))
        else $error("compression started on a partial block");

    // digest output follows the final fold
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest.valid) |-> ($past(state_reg) == ST_FOLD))
        else $error("digest shown without a final fold");

    // padding always ends on a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (fill_reg == 6'd0 && pad_reg))
        else $error("digest shown with bytes still buffered");

endmodule

`default_nettype wire
